/* rtl/integer_radix_conversion_assert.svh */
// assertion macros for the radix conversion block
`ifndef INTEGER_RADIX_CONVERSION_ASSERT_SVH
`define INTEGER_RADIX_CONVERSION_ASSERT_SVH

// condition implies consequence in the same cycle
`define IRC_ASSERT_NOW(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("irc check failed");

// condition implies consequence in the next cycle
`define IRC_ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("irc check failed");

// condition implies a later consequence
`define IRC_ASSERT_TWO(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> ##2 (cons)) \
      else $error("irc check failed");

`endif

/* rtl/irc_pkg.sv */
// ---------------------------------------------------------------------------
// irc_pkg
// types, constants and helpers shared by the radix conversion block
// ---------------------------------------------------------------------------
package irc_pkg;

   localparam int MAX_RADIX = 36;
   localparam int MIN_RADIX = 2;
   localparam logic [5:0] DEC_RADIX = 6'd10;
   localparam logic [6:0] CHAR_ZERO = 7'd48;
   localparam logic [6:0] CHAR_ALPHA = 7'd55;

   typedef struct packed {
      logic               arg_null;
      logic signed [63:0] num;
      logic signed [7:0]  source_base;
      logic signed [7:0]  target_base;
   } req_type;

   typedef struct packed {
      logic       is_null;
      logic       negative;
      logic [6:0] digit_char;
      logic       last;
   } rsp_type;

   // one queued job from the front to the back
   typedef struct packed {
      logic        is_null;
      logic [63:0] val;
      logic        tb_neg;
      logic [5:0]  tb_mag;
   } job_type;

   typedef struct packed {
      logic [5:0]  rem;
      logic [63:0] quo;
   } div_type;

   typedef enum logic [2:0] {
      F_IDLE, F_DIV, F_ACC, F_FIN, F_PUSH
   } front_state_type;

   typedef enum logic [1:0] {
      B_IDLE, B_DIV, B_RD, B_OUT
   } back_state_type;

   // four bits of restoring division by a small divisor
   function automatic div_type div_step(div_type cur, logic [5:0] dvs);
      div_type r;
      logic [6:0] t;
      r = cur;
      for (int i = 0; i < 4; i++) begin
         t = {r.rem, r.quo[63]};
         r.quo = {r.quo[62:0], 1'b0};
         if (t >= {1'b0, dvs}) begin
            t = t - {1'b0, dvs};
            r.quo[0] = 1'b1;
         end
         r.rem = t[5:0];
      end
      return r;
   endfunction

   function automatic logic [6:0] digit_char(logic [5:0] v);
      return (v < 6'd10) ? CHAR_ZERO + {1'b0, v} : CHAR_ALPHA + {1'b0, v};
   endfunction

   function automatic logic [7:0] mag8(logic [7:0] v);
      return v[7] ? 8'd0 - v : v;
   endfunction

endpackage

/* rtl/integer_radix_conversion.sv */
// ---------------------------------------------------------------------------
// integer_radix_conversion
// converts a 64-bit number between radixes 2..36, one digit per result
// ---------------------------------------------------------------------------
// An item is taken when start is high and busy is low; results come out on
// rsp_valid for one cycle each and cannot be held off. The front reads the
// decimal digits of num with a four-bit-per-cycle divider by ten, one full
// division (F_DIV) and one accumulate step (F_ACC) per decimal digit; it
// skips this when the source radix is ten or the item is null. A two-entry
// queue passes the value to the back, which finds each target digit with
// its own four-bit-per-cycle divider, then sends each digit from its digit
// memory through a read state and an output state. The back works on one
// number while the front takes the next item.
// ---------------------------------------------------------------------------
module integer_radix_conversion (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  irc_pkg::req_type req_data,
   output logic             rsp_valid,
   output irc_pkg::rsp_type rsp_data
);

   irc_pkg::job_type push_data, pop_data;
   logic push, full, pop, empty;

   irc_front u_front (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .push(push), .push_data(push_data), .full(full)
   );

   irc_queue u_queue (
      .clock(clock), .reset(reset), .push(push), .push_data(push_data),
      .full(full), .pop(pop), .empty(empty), .pop_data(pop_data)
   );

   irc_back u_back (
      .clock(clock), .reset(reset), .empty(empty), .pop_data(pop_data),
      .pop(pop), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

endmodule

/* rtl/irc_front.sv */
// ---------------------------------------------------------------------------
// irc_front
// accepts items, screens null cases and reads the source radix digits
// ---------------------------------------------------------------------------
module irc_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  irc_pkg::req_type  req_data,
   output logic              push,
   output irc_pkg::job_type  push_data,
   input  logic              full
);

   irc_pkg::front_state_type state_ff, state_in;
   irc_pkg::div_type div_ff, div_in, div_nx;
   irc_pkg::job_type job_ff, job_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [63:0] sum_ff, sum_in, place_ff, place_in;
   logic [5:0]  sbmag_ff, sbmag_in;
   logic        neg_ff, neg_in;
   logic [7:0]  sb_mag, tb_mag;
   logic        null_case;
   logic [3:0]  d;
   logic [67:0] prod;
   logic [69:0] pnext;
   logic [63:0] nsum;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= irc_pkg::F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      div_ff   <= div_in;
      job_ff   <= job_in;
      cnt_ff   <= cnt_in;
      sum_ff   <= sum_in;
      place_ff <= place_in;
      sbmag_ff <= sbmag_in;
      neg_ff   <= neg_in;
   end

   always_comb begin
      sb_mag = irc_pkg::mag8(req_data.source_base);
      tb_mag = irc_pkg::mag8(req_data.target_base);
      null_case = req_data.arg_null
         || sb_mag < 8'(irc_pkg::MIN_RADIX) || sb_mag > 8'(irc_pkg::MAX_RADIX)
         || tb_mag < 8'(irc_pkg::MIN_RADIX) || tb_mag > 8'(irc_pkg::MAX_RADIX)
         || (req_data.source_base[7] && !req_data.num[63]);
      div_nx = irc_pkg::div_step(div_ff, irc_pkg::DEC_RADIX);
      d = div_ff.rem[3:0];
      prod = place_ff * d;
      pnext = place_ff * sbmag_ff;
      nsum = sum_ff + prod[63:0];

      state_in = state_ff;
      div_in = div_ff;
      job_in = job_ff;
      cnt_in = cnt_ff;
      sum_in = sum_ff;
      place_in = place_ff;
      sbmag_in = sbmag_ff;
      neg_in = neg_ff;
      push = 1'b0;

      case (state_ff)
         irc_pkg::F_IDLE: begin
            if (start) begin
               job_in.is_null = null_case;
               job_in.tb_neg = req_data.target_base[7];
               job_in.tb_mag = tb_mag[5:0];
               job_in.val = req_data.num;
               neg_in = req_data.num[63];
               sbmag_in = sb_mag[5:0];
               sum_in = '0;
               place_in = 64'd1;
               cnt_in = '0;
               div_in.rem = '0;
               div_in.quo = req_data.num[63] ? 64'd0 - req_data.num : req_data.num;
               if (null_case) begin
                  job_in.val = '0;
                  state_in = irc_pkg::F_PUSH;
               end else if (req_data.source_base == 8'sd10) begin
                  state_in = irc_pkg::F_PUSH;
               end else begin
                  state_in = irc_pkg::F_DIV;
               end
            end
         end
         irc_pkg::F_DIV: begin
            div_in = div_nx;
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) state_in = irc_pkg::F_ACC;
         end
         irc_pkg::F_ACC: begin
            div_in.rem = '0;
            cnt_in = '0;
            if ({2'b00, d} >= sbmag_ff) begin
               // invalid digit drops what was built so far
               sum_in = '0;
               place_in = 64'd1;
               state_in = (div_ff.quo == '0) ? irc_pkg::F_FIN : irc_pkg::F_DIV;
            end else if (nsum[63] || nsum < {60'd0, d}) begin
               job_in.val = '1;
               state_in = irc_pkg::F_PUSH;
            end else begin
               sum_in = nsum;
               place_in = pnext[63:0];
               state_in = (div_ff.quo == '0) ? irc_pkg::F_FIN : irc_pkg::F_DIV;
            end
         end
         irc_pkg::F_FIN: begin
            job_in.val = neg_ff ? 64'd0 - sum_ff : sum_ff;
            state_in = irc_pkg::F_PUSH;
         end
         irc_pkg::F_PUSH: begin
            if (!full) begin
               push = 1'b1;
               state_in = irc_pkg::F_IDLE;
            end
         end
         default: state_in = irc_pkg::F_IDLE;
      endcase
   end

   assign busy = (state_ff != irc_pkg::F_IDLE);
   assign push_data = job_ff;

endmodule

/* rtl/irc_queue.sv */
// ---------------------------------------------------------------------------
// irc_queue
// two-entry job queue between the front and the back
// ---------------------------------------------------------------------------
module irc_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  irc_pkg::job_type push_data,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output irc_pkg::job_type pop_data
);

   irc_pkg::job_type ent_ff [2];
   logic       wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [1:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
      if (push) ent_ff[wptr_ff] <= push_data;
   end

   always_comb begin
      wptr_in = wptr_ff ^ push;
      rptr_in = rptr_ff ^ pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   assign full = (cnt_ff == 2'd2);
   assign empty = (cnt_ff == 2'd0);
   assign pop_data = ent_ff[rptr_ff];

endmodule

/* rtl/irc_back.sv */
// ---------------------------------------------------------------------------
// irc_back
// writes a job's value in the target radix and sends the digits out
// ---------------------------------------------------------------------------
module irc_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             empty,
   input  irc_pkg::job_type pop_data,
   output logic             pop,
   output logic             rsp_valid,
   output irc_pkg::rsp_type rsp_data
);

   irc_pkg::back_state_type state_ff, state_in;
   irc_pkg::div_type div_ff, div_in, div_nx;
   irc_pkg::rsp_type rsp_ff, rsp_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [3:0] cnt_ff, cnt_in;
   logic [6:0] n_ff, n_in;
   logic [5:0] idx_ff, idx_in;
   logic [5:0] tbmag_ff, tbmag_in;
   logic       neg_ff, neg_in;
   logic [5:0] mem [64];
   logic [5:0] rdata_ff;
   logic       mem_we;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= irc_pkg::B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      div_ff   <= div_in;
      rsp_ff   <= rsp_in;
      cnt_ff   <= cnt_in;
      n_ff     <= n_in;
      idx_ff   <= idx_in;
      tbmag_ff <= tbmag_in;
      neg_ff   <= neg_in;
   end

   // digit store, least significant digit at the lowest address
   always_ff @(posedge clock) begin
      if (mem_we) mem[n_ff[5:0]] <= div_nx.rem;
      if (state_ff == irc_pkg::B_RD) rdata_ff <= mem[idx_ff];
   end

   always_comb begin
      div_nx = irc_pkg::div_step(div_ff, tbmag_ff);
      state_in = state_ff;
      div_in = div_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = 1'b0;
      cnt_in = cnt_ff;
      n_in = n_ff;
      idx_in = idx_ff;
      tbmag_in = tbmag_ff;
      neg_in = neg_ff;
      pop = 1'b0;
      mem_we = 1'b0;

      case (state_ff)
         irc_pkg::B_IDLE: begin
            if (!empty) begin
               pop = 1'b1;
               tbmag_in = pop_data.tb_mag;
               neg_in = pop_data.val[63] && pop_data.tb_neg;
               div_in.rem = '0;
               div_in.quo = (pop_data.val[63] && pop_data.tb_neg) ?
                            64'd0 - pop_data.val : pop_data.val;
               cnt_in = '0;
               n_in = '0;
               if (pop_data.is_null) begin
                  rsp_valid_in = 1'b1;
                  rsp_in.is_null = 1'b1;
                  rsp_in.negative = 1'b0;
                  rsp_in.digit_char = '0;
                  rsp_in.last = 1'b1;
               end else begin
                  state_in = irc_pkg::B_DIV;
               end
            end
         end
         irc_pkg::B_DIV: begin
            div_in = div_nx;
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) begin
               mem_we = 1'b1;
               n_in = n_ff + 7'd1;
               idx_in = n_ff[5:0];
               div_in.rem = '0;
               if (div_nx.quo == '0) state_in = irc_pkg::B_RD;
            end
         end
         irc_pkg::B_RD: begin
            state_in = irc_pkg::B_OUT;
         end
         irc_pkg::B_OUT: begin
            rsp_valid_in = 1'b1;
            rsp_in.is_null = 1'b0;
            rsp_in.negative = neg_ff;
            rsp_in.digit_char = irc_pkg::digit_char(rdata_ff);
            rsp_in.last = (idx_ff == '0);
            if (idx_ff == '0) begin
               state_in = irc_pkg::B_IDLE;
            end else begin
               idx_in = idx_ff - 6'd1;
               state_in = irc_pkg::B_RD;
            end
         end
         default: state_in = irc_pkg::B_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

/* rtl/irc_checker.sv */
// ---------------------------------------------------------------------------
// irc_checker
// port-level checks on the result stream of the radix conversion block
// ---------------------------------------------------------------------------
`include "integer_radix_conversion_assert.svh"

module irc_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input irc_pkg::rsp_type rsp_data
);

   // a null result is alone and carries no digit
   `IRC_ASSERT_NOW(null_single, clock, reset, rsp_valid && rsp_data.is_null, rsp_data.last && !rsp_data.negative && rsp_data.digit_char == 7'd0)
   // digits of one transaction are not sent back to back
   `IRC_ASSERT_NEXT(digit_gap, clock, reset, rsp_valid && !rsp_data.last, !rsp_valid)
   `IRC_ASSERT_TWO(digit_follow, clock, reset, rsp_valid && !rsp_data.last, rsp_valid && !rsp_data.is_null && rsp_data.negative == $past(rsp_data.negative, 2))

endmodule

bind integer_radix_conversion irc_checker u_irc_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
);

/* tb/integer_radix_conversion_tb.sv */
// ---------------------------------------------------------------------------
// integer_radix_conversion_tb
// drives random and corner-case conversions into the block and compares
// every digit it sends against digits computed here from the same item
// ---------------------------------------------------------------------------
module integer_radix_conversion_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT = 20000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   irc_pkg::req_type req_data = '0;
   logic             rsp_valid;
   irc_pkg::rsp_type rsp_data;

   irc_pkg::req_type pending_q[$];
   irc_pkg::rsp_type digits_q[$];
   int      errors = 0;
   int      hold_cycles = 0;
   int      idle_cycles = 0;
   bit      drain_now = 1'b0;
   bit      drain_req = 1'b0;

   integer_radix_conversion dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   always #10 clock = ~clock;

   function automatic irc_pkg::rsp_type make_rsp(bit nul, bit neg, logic [6:0] ch, bit lst);
      irc_pkg::rsp_type r;
      r.is_null = nul;
      r.negative = neg;
      r.digit_char = ch;
      r.last = lst;
      return r;
   endfunction

   function automatic logic [63:0] abs64(logic [63:0] v);
      return v[63] ? 64'd0 - v : v;
   endfunction

   // decimal digits of num taken as digits of radix rad
   function automatic logic [63:0] reread_digits(logic [63:0] num, logic [63:0] rad);
      logic [63:0] rest, sum, place, d;
      rest = abs64(num);
      sum = 0;
      place = 1;
      do begin
         d = rest % 10;
         if (d >= rad) begin
            sum = 0;
            place = 1;
         end else begin
            sum = sum + d * place;
            if (sum[63] || sum < d) return '1;
            place = place * rad;
         end
         rest = rest / 10;
      end while (rest > 0);
      return num[63] ? 64'd0 - sum : sum;
   endfunction

   task automatic predict_digits(irc_pkg::req_type it);
      int sb, tb, sbm, tbm, n;
      logic [63:0] val, rest;
      logic [5:0] dig[$];
      bit neg;
      sb = it.source_base;
      tb = it.target_base;
      sbm = sb < 0 ? -sb : sb;
      tbm = tb < 0 ? -tb : tb;
      if (it.arg_null || sbm < irc_pkg::MIN_RADIX || sbm > irc_pkg::MAX_RADIX
          || tbm < irc_pkg::MIN_RADIX || tbm > irc_pkg::MAX_RADIX
          || (sb < 0 && !it.num[63])) begin
         digits_q.push_back(make_rsp(1'b1, 1'b0, 7'd0, 1'b1));
         return;
      end
      val = it.num;
      if (sb != 10) val = reread_digits(it.num, sbm);
      rest = tb < 0 ? abs64(val) : val;
      do begin
         dig.push_front(6'(rest % tbm));
         rest = rest / tbm;
      end while (rest > 0);
      neg = val[63] && tb < 0;
      n = dig.size();
      for (int k = 0; k < n; k++)
         digits_q.push_back(make_rsp(1'b0, neg,
            dig[k] < 10 ? 7'd48 + dig[k] : 7'd55 + dig[k], k == n - 1));
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !busy) begin
         predict_digits(req_data);
         hold_cycles <= $urandom_range(0, 4);
         start <= 1'b0;
      end else if (!start) begin
         if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
         end else if (drain_req && digits_q.size() != 0) begin
            // hold off until every digit in flight is out
         end else if (pending_q.size() != 0) begin
            req_data <= pending_q.pop_front();
            start <= 1'b1;
            drain_now <= drain_req;
         end
      end
   end

   always @(posedge clock) if (drain_now) drain_req <= 1'b0;

   // monitor and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            if (digits_q.size() == 0) begin
               $display("%0t unexpected transaction: actual %p", $realtime, rsp_data);
               errors++;
            end else begin
               irc_pkg::rsp_type e;
               e = digits_q.pop_front();
               if (e !== rsp_data) begin
                  $display("%0t mismatch: expected %p actual %p", $realtime, e, rsp_data);
                  errors++;
               end
            end
         end
         if (rsp_valid || (start && !busy)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   function automatic logic [63:0] rand_num();
      logic [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 5))
         0: v = $urandom_range(0, 99);
         1: v = -$signed(64'($urandom_range(0, 99999)));
         2: v = {$urandom, $urandom} % 64'd100000000;
         3: v = {32'h0, $urandom};
         default: ;
      endcase
      return v;
   endfunction

   function automatic logic [7:0] rand_base();
      int b;
      b = $urandom_range(2, 36);
      case ($urandom_range(0, 9))
         0: return 8'($urandom);
         1, 2: return 8'(-b);
         3: return 8'd10;
         default: return 8'(b);
      endcase
   endfunction

   task automatic add_item(bit nul, logic [63:0] n, logic [7:0] sb, logic [7:0] tb);
      irc_pkg::req_type it;
      it.arg_null = nul;
      it.num = n;
      it.source_base = sb;
      it.target_base = tb;
      pending_q.push_back(it);
   endtask

   initial begin
      irc_pkg::req_type it;
      // directed corners
      add_item(1'b1, 64'd123, 8'd10, 8'd16);
      add_item(1'b0, 64'd0, 8'd10, 8'd2);
      add_item(1'b0, 64'h7FFF_FFFF_FFFF_FFFF, 8'd10, 8'd36);
      add_item(1'b0, 64'h8000_0000_0000_0000, 8'd10, -8'sd2);
      add_item(1'b0, 64'h8000_0000_0000_0000, 8'd10, 8'd2);
      add_item(1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 8'd10, 8'd16);
      add_item(1'b0, 64'd255, 8'd1, 8'd10);
      add_item(1'b0, 64'd255, 8'd37, 8'd10);
      add_item(1'b0, 64'd255, 8'd10, 8'd0);
      add_item(1'b0, 64'd255, 8'd10, -8'sd37);
      add_item(1'b0, 64'd255, 8'h80, 8'h7F);
      add_item(1'b0, 64'd101, -8'sd2, 8'd10);
      add_item(1'b0, -64'sd101, -8'sd2, -8'sd10);
      add_item(1'b0, 64'd1921, 8'd2, 8'd10);
      add_item(1'b0, 64'd1234567, 8'd36, -8'sd36);
      add_item(1'b0, 64'd9999999999999999999, 8'd36, 8'd10);
      add_item(1'b0, 64'h7FFF_FFFF_FFFF_FFFF, 8'd11, 8'd10);
      add_item(1'b0, -64'sd35, 8'd16, 8'd16);
      add_item(1'b0, -64'sd35, 8'd16, -8'sd16);
      add_item(1'b0, 64'd1010, 8'd2, 8'd2);
      add_item(1'b0, 64'h8000_0000_0000_0000, -8'sd36, -8'sd36);
      for (int i = 0; i < 320; i++) begin
         it.arg_null = ($urandom_range(0, 19) == 0);
         it.num = rand_num();
         it.source_base = rand_base();
         it.target_base = rand_base();
         pending_q.push_back(it);
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      wait (pending_q.size() < 160);
      @(posedge clock);
      drain_req <= 1'b1;
      wait (pending_q.size() == 0 && !start);
      wait (digits_q.size() == 0);
      repeat (200) @(posedge clock);
      if (errors == 0 && digits_q.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
